// ----- sv/gfbk_pkg.sv -----
package gfbk_pkg;

  // Sizes of the stores
  localparam int unsigned MAX_GROUPS    = 16;
  localparam int unsigned MAX_POSITIONS = 256;
  localparam int unsigned SLOT_W        = $clog2(MAX_GROUPS);
  localparam int unsigned IDX_W         = $clog2(MAX_POSITIONS);
  localparam int unsigned CNT_W         = $clog2(MAX_GROUPS + 1);

  // Field widths fixed by the interface
  localparam int unsigned POS_W = 9;
  localparam int unsigned KEY_W = 32;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [POS_W-1:0] LIMIT_RESET = POS_W'(MAX_POSITIONS);

  typedef struct packed {
    logic              operation;
    logic signed [KEY_W-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             empty_res;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH_HIT,
    ST_PUSH_NEW,
    ST_POP_SEL,
    ST_POP_UPD
  } state_e;

  // Control into the key scanner
  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  key;
  } scan_ctl_t;

  // Status out of the key scanner
  typedef struct packed {
    logic              busy;
    logic              done;
    logic              hit;
    logic              free_ok;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] free_slot;
  } scan_stat_t;

  // Next slot of the group order ring
  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] i);
    ring_next = (i == SLOT_W'(MAX_GROUPS - 1)) ? '0 : i + SLOT_W'(1);
  endfunction

endpackage

// ----- sv/gfbk_key_scan.sv -----
module gfbk_key_scan import gfbk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_ctl_t         ctl_i,
  input  logic [KEY_W-1:0]  slot_key_i,
  input  logic              slot_valid_i,
  output logic [SLOT_W-1:0] idx_o,
  output scan_stat_t        stat_o
);

  logic              busy_q, busy_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              have_free_q, have_free_d;
  logic [SLOT_W-1:0] free_q, free_d;
  logic [KEY_W-1:0]  key_q;
  logic              match, last;

  // One shared comparator, one slot per cycle
  assign match = slot_valid_i && (slot_key_i == key_q);
  assign last  = (cnt_q == SLOT_W'(MAX_GROUPS - 1));
  assign idx_o = cnt_q;

  always_comb begin
    stat_o.busy      = busy_q;
    stat_o.done      = busy_q && (match || last);
    stat_o.hit       = match;
    stat_o.free_ok   = have_free_q || !slot_valid_i;
    stat_o.hit_slot  = cnt_q;
    stat_o.free_slot = have_free_q ? free_q : cnt_q;
  end

  // Scan counter and first free slot
  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    have_free_d = have_free_q;
    free_d      = free_q;
    if (ctl_i.start) begin
      busy_d      = 1'b1;
      cnt_d       = '0;
      have_free_d = 1'b0;
    end else if (busy_q) begin
      if (!slot_valid_i && !have_free_q) begin
        have_free_d = 1'b1;
        free_d      = cnt_q;
      end
      if (match || last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      have_free_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      have_free_q <= have_free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_q <= free_d;
    if (ctl_i.start) begin
      key_q <= ctl_i.key;
    end
  end

endmodule

// ----- sv/gfbk_link_mem.sv -----
module gfbk_link_mem import gfbk_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [IDX_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [IDX_W-1:0] rdata_o
);

  // Next-position links, one entry per position
  logic [IDX_W-1:0] mem_q [MAX_POSITIONS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- sv/grouped_fifo_by_key.sv -----
// Channel  | Direction | Handshake                  | Payload
// in       | input     | in_valid_i / in_stall_o    | in_data_i  (in_item_t)
// out      | output    | out_valid_o / out_stall_i  | out_data_o (out_item_t)
// cfg      | input     | cfg_wr_en_i                | cfg_wr_data_i (item limit)
//
// Push: accept, key scan of 1 to 16 slots (one per cycle through a single
// 32-bit comparator), update unless a new key finds no free slot; one over
// the limit ends at acceptance. Pop: select, plus an update (link read) when
// the group keeps positions. One transaction in work at a time; in_stall_o
// is high until it ends. A pop holds while the result register is stalled
// by out_stall_i. Reset clears control, valid bits and counters; no sweep.
module grouped_fifo_by_key import gfbk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_wr_en_i,
  input  logic [POS_W-1:0] cfg_wr_data_i
);

  state_e state_q, state_d;

  logic [POS_W-1:0]  limit_q;
  logic [POS_W-1:0]  next_pos_q;
  logic [SLOT_W-1:0] order_rd_q, order_wr_q;
  logic [CNT_W-1:0]  order_cnt_q;
  logic [SLOT_W-1:0] slot_q;
  logic              out_valid_q;
  out_item_t         out_data_q;

  // Key of the push in work, held from acceptance
  logic [KEY_W-1:0]  push_key_q;

  // Group tables
  logic [MAX_GROUPS-1:0] valid_q;
  logic [KEY_W-1:0]  key_q   [MAX_GROUPS];
  logic [IDX_W-1:0]  first_q [MAX_GROUPS];
  logic [IDX_W-1:0]  last_q  [MAX_GROUPS];
  logic [POS_W-1:0]  size_q  [MAX_GROUPS];
  logic [SLOT_W-1:0] order_q [MAX_GROUPS];

  logic              accept, push_ok, out_free;
  logic [POS_W-1:0]  limit_eff;
  logic [IDX_W-1:0]  new_idx;
  logic [SLOT_W-1:0] pop_slot;
  logic [IDX_W-1:0]  pop_idx;

  scan_ctl_t         scan_ctl;
  scan_stat_t        scan_stat;
  logic [SLOT_W-1:0] scan_idx;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr, mem_rdata;

  assign accept    = in_valid_i && !in_stall_o;
  assign limit_eff = (limit_q > POS_W'(MAX_POSITIONS)) ? POS_W'(MAX_POSITIONS) : limit_q;
  assign push_ok   = (next_pos_q <= limit_eff);
  assign new_idx   = IDX_W'(next_pos_q - POS_W'(1));
  assign out_free  = !(out_valid_q && out_stall_i);
  assign pop_slot  = order_q[order_rd_q];
  assign pop_idx   = first_q[pop_slot];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  gfbk_key_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .slot_key_i  (key_q[scan_idx]),
    .slot_valid_i(valid_q[scan_idx]),
    .idx_o       (scan_idx),
    .stat_o      (scan_stat)
  );

  gfbk_link_mem u_link (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(new_idx),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.operation == OP_POP) begin
            state_d = ST_POP_SEL;
          end else if (push_ok) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          if (scan_stat.hit) begin
            state_d = ST_PUSH_HIT;
          end else if (scan_stat.free_ok) begin
            state_d = ST_PUSH_NEW;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PUSH_HIT: state_d = ST_IDLE;
      ST_PUSH_NEW: state_d = ST_IDLE;
      ST_POP_SEL: begin
        if (out_free) begin
          if (order_cnt_q != '0 && size_q[pop_slot] > POS_W'(1)) begin
            state_d = ST_POP_UPD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_POP_UPD: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    scan_ctl.start = 1'b0;
    scan_ctl.key   = in_data_i.key_value;
    mem_we         = 1'b0;
    mem_waddr      = last_q[slot_q];
    mem_re         = 1'b0;
    mem_raddr      = pop_idx;
    case (state_q)
      ST_IDLE:     scan_ctl.start = accept && (in_data_i.operation == OP_PUSH) && push_ok;
      ST_PUSH_HIT: mem_we = 1'b1;
      ST_POP_SEL:  mem_re = out_free && (order_cnt_q != '0);
      default:     ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      next_pos_q  <= POS_W'(1);
      order_rd_q  <= '0;
      order_wr_q  <= '0;
      order_cnt_q <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        limit_q <= cfg_wr_data_i;
      end
      // Result register: loaded by a pop, freed when taken
      if (state_q == ST_POP_SEL && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_PUSH_HIT: next_pos_q <= next_pos_q + POS_W'(1);
        ST_PUSH_NEW: begin
          next_pos_q      <= next_pos_q + POS_W'(1);
          valid_q[slot_q] <= 1'b1;
          order_wr_q      <= ring_next(order_wr_q);
          order_cnt_q     <= order_cnt_q + CNT_W'(1);
        end
        ST_POP_SEL: begin
          if (out_free) begin
            if (order_cnt_q != '0 && size_q[pop_slot] <= POS_W'(1)) begin
              valid_q[pop_slot] <= 1'b0;
              order_rd_q        <= ring_next(order_rd_q);
              order_cnt_q       <= order_cnt_q - CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers and group tables
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SCAN: begin
        if (scan_stat.done) begin
          slot_q <= scan_stat.hit ? scan_stat.hit_slot : scan_stat.free_slot;
        end
      end
      ST_PUSH_HIT: begin
        last_q[slot_q] <= new_idx;
        size_q[slot_q] <= size_q[slot_q] + POS_W'(1);
      end
      ST_PUSH_NEW: begin
        key_q[slot_q]       <= push_key_q;
        first_q[slot_q]     <= new_idx;
        last_q[slot_q]      <= new_idx;
        size_q[slot_q]      <= POS_W'(1);
        order_q[order_wr_q] <= slot_q;
      end
      ST_POP_SEL: begin
        if (out_free) begin
          slot_q <= pop_slot;
          if (order_cnt_q == '0) begin
            out_data_q.position  <= '0;
            out_data_q.empty_res <= 1'b1;
          end else begin
            out_data_q.position  <= POS_W'(pop_idx) + POS_W'(1);
            out_data_q.empty_res <= 1'b0;
            if (size_q[pop_slot] <= POS_W'(1)) begin
              size_q[pop_slot] <= '0;
            end
          end
        end
      end
      ST_POP_UPD: begin
        first_q[slot_q] <= mem_rdata;
        size_q[slot_q]  <= size_q[slot_q] - POS_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (scan_ctl.start) begin
      push_key_q <= in_data_i.key_value;
    end
  end

  // Every queued group holds exactly one valid slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(order_cnt_q))
    else $error("valid slots disagree with queued group count");

  // A result only appears after a pop selection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_POP_SEL)
    else $error("result raised outside pop");

  // Position counter never passes one beyond the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_pos_q <= POS_W'(MAX_POSITIONS + 1))
    else $error("position counter overran");

  // A pending result is never overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result changed");

endmodule

// ----- verif/tb_grouped_fifo_by_key.sv -----
module tb_grouped_fifo_by_key;
  import gfbk_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;     // outlasts the longest push
  localparam int unsigned DRAIN_GUARD   = 20000;
  localparam int unsigned POOL_SIZE     = 24;     // more keys than table slots

  typedef enum int unsigned {SINK_OPEN, SINK_HALF, SINK_CHOKED, SINK_LIGHT} sink_mode_e;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_item_t         in_data     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [POS_W-1:0] cfg_wr_data = '0;

  // Transactions waiting to be driven, and popped positions still owed
  in_item_t  pending_q[$];
  out_item_t owed_pos_q[$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int unsigned issued   = 0;
  int unsigned accepted = 0;
  int unsigned errors   = 0;
  bit          in_taken = 1'b0;

  // Shadow of the grouped queue
  logic [KEY_W-1:0]  grp_key   [MAX_GROUPS];
  logic              grp_used  [MAX_GROUPS];
  logic [IDX_W-1:0]  grp_head  [MAX_GROUPS];
  logic [IDX_W-1:0]  grp_tail  [MAX_GROUPS];
  int unsigned       grp_len   [MAX_GROUPS];
  logic [IDX_W-1:0]  pos_next  [MAX_POSITIONS];
  logic [SLOT_W-1:0] ring_slot [MAX_GROUPS];
  logic [SLOT_W-1:0] ring_rd, ring_wr;
  int unsigned       ring_cnt;
  int unsigned       stamp_next;
  logic [POS_W-1:0]  pos_limit;

  // Coverage tallies for the summary
  int unsigned n_stamped = 0, n_blocked = 0, n_full = 0, n_joined = 0;
  int unsigned n_popped = 0, n_empty = 0, n_cfg = 0;

  grouped_fifo_by_key dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .in_data_i     (in_data),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_o    (out_data),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data)
  );

  always #1 clk = ~clk;

  task automatic clear_shadow();
    for (int g = 0; g < MAX_GROUPS; g++) begin
      grp_key[g]   = '0;
      grp_used[g]  = 1'b0;
      grp_head[g]  = '0;
      grp_tail[g]  = '0;
      grp_len[g]   = 0;
      ring_slot[g] = '0;
    end
    for (int p = 0; p < MAX_POSITIONS; p++) pos_next[p] = '0;
    ring_rd    = '0;
    ring_wr    = '0;
    ring_cnt   = 0;
    stamp_next = 1;
    pos_limit  = LIMIT_RESET;
  endtask

  // Stamp a pushed key with the next position and file it under its group
  task automatic stamp_key(input logic [KEY_W-1:0] key);
    int unsigned      lim;
    int               slot;
    bit               hit;
    bit               spare;
    logic [IDX_W-1:0] idx;
    lim = (32'(pos_limit) > MAX_POSITIONS) ? MAX_POSITIONS : 32'(pos_limit);
    if (stamp_next > lim) begin
      n_blocked++;
      return;
    end
    idx  = IDX_W'(stamp_next - 1);
    slot = 0;
    hit  = 1'b0;
    for (int g = 0; g < MAX_GROUPS; g++)
      if (!hit && grp_used[g] && grp_key[g] == key) begin
        slot = g;
        hit  = 1'b1;
      end
    if (hit) begin
      pos_next[grp_tail[slot]] = idx;
      grp_tail[slot] = idx;
      grp_len[slot]++;
      n_joined++;
    end else begin
      spare = 1'b0;
      for (int g = 0; g < MAX_GROUPS; g++)
        if (!spare && !grp_used[g]) begin
          slot  = g;
          spare = 1'b1;
        end
      // new key with every slot taken: dropped, no position used
      if (!spare) begin
        n_full++;
        return;
      end
      grp_used[slot]     = 1'b1;
      grp_key[slot]      = key;
      grp_head[slot]     = idx;
      grp_tail[slot]     = idx;
      grp_len[slot]      = 1;
      ring_slot[ring_wr] = SLOT_W'(slot);
      ring_wr  = (ring_wr == SLOT_W'(MAX_GROUPS - 1)) ? '0 : ring_wr + 1'b1;
      ring_cnt++;
    end
    stamp_next++;
    n_stamped++;
  endtask

  // Oldest position of the first group, or the empty answer
  task automatic take_oldest(output out_item_t res);
    logic [SLOT_W-1:0] g;
    logic [IDX_W-1:0]  idx;
    if (ring_cnt == 0) begin
      res.position  = '0;
      res.empty_res = 1'b1;
      n_empty++;
      return;
    end
    g   = ring_slot[ring_rd];
    idx = grp_head[g];
    res.position  = POS_W'(idx) + POS_W'(1);
    res.empty_res = 1'b0;
    n_popped++;
    if (grp_len[g] > 1) begin
      grp_head[g] = pos_next[idx];
      grp_len[g]--;
    end else begin
      grp_used[g] = 1'b0;
      grp_len[g]  = 0;
      ring_rd  = (ring_rd == SLOT_W'(MAX_GROUPS - 1)) ? '0 : ring_rd + 1'b1;
      ring_cnt--;
    end
  endtask

  task automatic queue_item(input logic op, input logic [KEY_W-1:0] key);
    in_item_t it;
    it.operation = op;
    it.key_value = key;
    pending_q.push_back(it);
    issued++;
  endtask

  task automatic queue_random(input int unsigned push_pct);
    if ($urandom_range(0, 99) < push_pct) begin
      if ($urandom_range(0, 99) < 85)
        queue_item(OP_PUSH, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
      else
        queue_item(OP_PUSH, $urandom);
    end else begin
      queue_item(OP_POP, $urandom);
    end
  endtask

  // Block is idle once every transaction is in and every result is out
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    while ((accepted != issued || owed_pos_q.size() != 0) && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    if (owed_pos_q.size() != 0 || accepted != issued) begin
      errors++;
      $display("%0t: stuck, %0d results still owed, %0d transactions not taken",
               $time, owed_pos_q.size(), issued - accepted);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input int unsigned value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= POS_W'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned limit, input int unsigned push_pct,
                           input int unsigned count);
    write_limit(limit);
    repeat (count) queue_random(push_pct);
    wait_idle();
  endtask

  // Result check, register shadow and prediction, all on the rising edge
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    out_item_t res;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (owed_pos_q.size() == 0) begin
          errors++;
          $display("%0t: result with none owed, expected nothing, got position %0d empty %0b",
                   $time, out_data.position, out_data.empty_res);
        end else begin
          want = owed_pos_q.pop_front();
          if (out_data.position !== want.position) begin
            errors++;
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want.position, out_data.position);
          end
          if (out_data.empty_res !== want.empty_res) begin
            errors++;
            $display("%0t: empty flag mismatch, expected %0b, got %0b",
                     $time, want.empty_res, out_data.empty_res);
          end
        end
      end
      if (cfg_wr_en) begin
        pos_limit = cfg_wr_data;
        n_cfg++;
      end
      if (in_valid && !in_stall) begin
        accepted++;
        in_taken = 1'b1;
        if (in_data.operation == OP_POP) begin
          take_oldest(res);
          owed_pos_q.push_back(res);
        end else begin
          stamp_key(in_data.key_value);
        end
      end
    end
  end

  // Sender: bursts of back-to-back transactions with random gaps between
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin : driver
    logic     nv;
    in_item_t nd;
    nv = in_valid;
    nd = in_data;
    if (in_taken) nv = 1'b0;
    in_taken = 1'b0;
    if (!nv && rst_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        nd = pending_q.pop_front();
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  // Receiver: stall pattern switches between modes every so often
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;

  always @(negedge clk) begin : sink
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(20, 120);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_OPEN:   out_stall <= 1'b0;
      SINK_HALF:   out_stall <= ($urandom_range(0, 1) == 1);
      SINK_CHOKED: out_stall <= ($urandom_range(0, 9) < 8);
      default:     out_stall <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin : stimulus
    int unsigned rounds;
    clear_shadow();
    for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: pop on empty, key extremes, joining an existing group
    queue_item(OP_POP,  $urandom);
    queue_item(OP_PUSH, 32'h8000_0000);
    queue_item(OP_PUSH, 32'h7fff_ffff);
    queue_item(OP_PUSH, 32'h8000_0000);
    queue_item(OP_PUSH, 32'h0000_0000);
    queue_item(OP_PUSH, 32'hffff_ffff);
    queue_item(OP_PUSH, 32'h7fff_ffff);
    // first group empties and leaves the order
    queue_item(OP_POP,  32'hffff_ffff);
    queue_item(OP_POP,  32'h0000_0000);
    // fill the key table, then a new key that must be dropped
    for (int k = 0; k < 13; k++) queue_item(OP_PUSH, 32'h0001_0000 + k);
    queue_item(OP_PUSH, 32'h5a5a_a5a5);
    queue_item(OP_PUSH, 32'h0000_0000);
    queue_item(OP_POP,  $urandom);
    wait_idle();

    // Limit settings: all pushes blocked, clamp above the store size, edges
    run_phase(0,   60, 75);
    run_phase(48,  65, 75);
    run_phase(511, 60, 75);
    run_phase(100, 70, 75);
    run_phase(300, 60, 75);
    run_phase(256, 65, 75);
    write_limit(511);
    repeat (75) queue_random(75);
    wait_idle();

    // Keep pushing until the last position is stamped, then empty it all
    rounds = 0;
    while (stamp_next <= MAX_POSITIONS && rounds < 30) begin
      repeat (20) queue_random(85);
      wait_idle();
      rounds++;
    end
    rounds = 0;
    while (ring_cnt > 0 && rounds < 30) begin
      repeat (20) queue_item(OP_POP, $urandom);
      wait_idle();
      rounds++;
    end
    queue_item(OP_POP, $urandom);
    wait_idle();

    $display("Covered %0d transactions over %0d limit writes: %0d stamped, %0d joined a group",
             accepted, n_cfg, n_stamped, n_joined);
    $display("  %0d over the limit, %0d dropped on a full table, %0d popped, %0d empty pops",
             n_blocked, n_full, n_popped, n_empty);
    if (errors == 0) begin
      $display("** grouped_fifo_by_key: PASSED **");
    end else begin
      $display("%0d errors", errors);
      $display("** grouped_fifo_by_key: FAILED **");
    end
    $finish;
  end

  // Safety net against a hung handshake
  initial begin : watchdog
    #1000000;
    $display("%0t: timeout", $time);
    $display("** grouped_fifo_by_key: FAILED **");
    $finish;
  end

endmodule
